// ===== rtl/core/ncle_pkg.sv =====
package ncle_pkg;

  // Item kinds carried in the slave-side tuser field.
  typedef enum logic [2:0] {
    OP_CONTROL  = 3'd0,
    OP_PERIOD   = 3'd1,
    OP_LENGTH   = 3'd2,
    OP_ENABLE   = 3'd3,
    OP_TIMER    = 3'd4,
    OP_ENVELOPE = 3'd5
  } ncle_op_e;

  localparam int unsigned LfsrWidth   = 15;
  localparam int unsigned TimerWidth  = 12;
  localparam int unsigned TapLong     = 1;
  localparam int unsigned TapShort    = 6;
  localparam int unsigned FeedbackPos = 14;
  localparam logic [3:0]  EnvTop      = 4'd15;

  // Result packed from the lowest bit up: noise_bit, envelope_level, volume,
  // length_count, channel_on.
  typedef struct packed {
    logic       channel_on;
    logic [7:0] length_count;
    logic [3:0] volume;
    logic [3:0] envelope_level;
    logic       noise_bit;
  } ncle_result_t;

  // Timer period selected by a period write.
  function automatic logic [TimerWidth-1:0] period_lookup(input logic [3:0] idx);
    logic [TimerWidth-1:0] p;
    case (idx)
      4'd0:    p = 12'd4;
      4'd1:    p = 12'd8;
      4'd2:    p = 12'd16;
      4'd3:    p = 12'd32;
      4'd4:    p = 12'd64;
      4'd5:    p = 12'd96;
      4'd6:    p = 12'd128;
      4'd7:    p = 12'd160;
      4'd8:    p = 12'd202;
      4'd9:    p = 12'd254;
      4'd10:   p = 12'd380;
      4'd11:   p = 12'd508;
      4'd12:   p = 12'd762;
      4'd13:   p = 12'd1016;
      4'd14:   p = 12'd2034;
      default: p = 12'd4068;
    endcase
    return p;
  endfunction

  // Length count loaded by a length write.
  function automatic logic [7:0] length_lookup(input logic [4:0] idx);
    logic [7:0] l;
    case (idx)
      5'd0:    l = 8'd10;
      5'd1:    l = 8'd254;
      5'd2:    l = 8'd20;
      5'd3:    l = 8'd2;
      5'd4:    l = 8'd40;
      5'd5:    l = 8'd4;
      5'd6:    l = 8'd80;
      5'd7:    l = 8'd6;
      5'd8:    l = 8'd160;
      5'd9:    l = 8'd8;
      5'd10:   l = 8'd60;
      5'd11:   l = 8'd10;
      5'd12:   l = 8'd14;
      5'd13:   l = 8'd12;
      5'd14:   l = 8'd26;
      5'd15:   l = 8'd14;
      5'd16:   l = 8'd12;
      5'd17:   l = 8'd16;
      5'd18:   l = 8'd24;
      5'd19:   l = 8'd18;
      5'd20:   l = 8'd48;
      5'd21:   l = 8'd20;
      5'd22:   l = 8'd96;
      5'd23:   l = 8'd22;
      5'd24:   l = 8'd192;
      5'd25:   l = 8'd24;
      5'd26:   l = 8'd72;
      5'd27:   l = 8'd26;
      5'd28:   l = 8'd16;
      5'd29:   l = 8'd28;
      5'd30:   l = 8'd32;
      default: l = 8'd30;
    endcase
    return l;
  endfunction

endpackage

// ===== rtl/core/noise_channel_lfsr_envelope_top.sv =====
// Noise channel with a 15-bit LFSR, timer divider, envelope and length count.
//
// Input stream (s_axis_*): tuser carries the item kind (control, period,
// length or enable write, timer tick, envelope tick); tdata carries the
// register write byte, which tick items ignore. Every transfer produces
// exactly one result on the output stream; spare codes leave state alone.
// Output stream (m_axis_*): tdata carries the LFSR bit 0, the envelope
// level, the selected volume, the length count and the enable flag.
//
// The result of an input transfer is registered in the output register, or
// in the skid register while a waiting result is not taken. Throughput is
// one item per clock while the skid register is empty. A two-entry output
// buffer (output register plus a skid register) lets an item be taken while
// the previous result still waits; tready drops only when both entries are
// full, and recovers in the cycle after the receiver takes a result.
//
// Reset clears all state, with the LFSR set to one, and empties the output
// buffer. A stalled receiver holds the result steady until it is taken.
module noise_channel_lfsr_envelope_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data
  input  logic [2:0]  s_axis_tuser,  // [2:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // [0] noise_bit, [4:1] envelope_level,
                                     // [8:5] volume, [16:9] length_count,
                                     // [17] channel_on, [23:18] zero
);
  import ncle_pkg::*;

  // Channel state.
  logic [LfsrWidth-1:0]  lfsr_q, lfsr_d;
  logic [TimerWidth-1:0] timer_count_q, timer_count_d;
  logic [TimerWidth-1:0] timer_reload_q, timer_reload_d;
  logic                  short_mode_q, short_mode_d;
  logic [3:0]            fixed_volume_q, fixed_volume_d;
  logic                  loop_flag_q, loop_flag_d;
  logic                  env_on_q, env_on_d;
  logic                  restart_q, restart_d;
  logic [3:0]            env_divider_q, env_divider_d;
  logic [3:0]            env_level_q, env_level_d;
  logic [7:0]            len_count_q, len_count_d;
  logic                  chan_enabled_q, chan_enabled_d;

  // Output buffer.
  logic                  out_valid_q, skid_valid_q;
  ncle_result_t          out_q, skid_q;
  ncle_result_t          result;

  logic                  in_xfer, out_xfer, feedback;
  ncle_op_e              op;

  assign op       = ncle_op_e'(s_axis_tuser);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = out_valid_q && m_axis_tready;
  assign feedback = lfsr_q[0] ^ (short_mode_q ? lfsr_q[TapShort] : lfsr_q[TapLong]);

  // Next channel state for the item on the input.
  always_comb begin
    lfsr_d         = lfsr_q;
    timer_count_d  = timer_count_q;
    timer_reload_d = timer_reload_q;
    short_mode_d   = short_mode_q;
    fixed_volume_d = fixed_volume_q;
    loop_flag_d    = loop_flag_q;
    env_on_d       = env_on_q;
    restart_d      = restart_q;
    env_divider_d  = env_divider_q;
    env_level_d    = env_level_q;
    len_count_d    = len_count_q;
    chan_enabled_d = chan_enabled_q;
    case (op)
      OP_CONTROL: begin
        fixed_volume_d = s_axis_tdata[3:0];
        env_on_d       = !s_axis_tdata[4];
        loop_flag_d    = s_axis_tdata[5];
        restart_d      = 1'b1;
      end
      OP_PERIOD: begin
        timer_reload_d = period_lookup(s_axis_tdata[3:0]);
        short_mode_d   = s_axis_tdata[7];
      end
      OP_LENGTH: begin
        len_count_d = length_lookup(s_axis_tdata[7:3]);
        restart_d   = 1'b1;
      end
      OP_ENABLE: begin
        chan_enabled_d = (s_axis_tdata != 8'd0);
        if (s_axis_tdata == 8'd0) begin
          len_count_d = 8'd0;
        end
      end
      OP_TIMER: begin
        if (timer_count_q == '0) begin
          timer_count_d = timer_reload_q;
          lfsr_d        = {feedback, lfsr_q[LfsrWidth-1:1]};
        end else begin
          timer_count_d = timer_count_q - 1'b1;
        end
      end
      OP_ENVELOPE: begin
        if (restart_q) begin
          env_level_d   = EnvTop;
          env_divider_d = fixed_volume_q;
          restart_d     = 1'b0;
        end else if (env_divider_q != 4'd0) begin
          env_divider_d = env_divider_q - 4'd1;
        end else begin
          if (env_level_q != 4'd0) begin
            env_level_d = env_level_q - 4'd1;
          end else if (loop_flag_q) begin
            env_level_d = EnvTop;
          end
          env_divider_d = fixed_volume_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Result seen after this item.
  always_comb begin
    result.noise_bit      = lfsr_d[0];
    result.envelope_level = env_level_d;
    result.volume         = env_on_d ? env_level_d : fixed_volume_d;
    result.length_count   = len_count_d;
    result.channel_on     = chan_enabled_d;
  end

  // State registers update on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q         <= LfsrWidth'(1);
      timer_count_q  <= '0;
      timer_reload_q <= '0;
      short_mode_q   <= 1'b0;
      fixed_volume_q <= 4'd0;
      loop_flag_q    <= 1'b0;
      env_on_q       <= 1'b0;
      restart_q      <= 1'b0;
      env_divider_q  <= 4'd0;
      env_level_q    <= 4'd0;
      len_count_q    <= 8'd0;
      chan_enabled_q <= 1'b0;
    end else if (in_xfer) begin
      lfsr_q         <= lfsr_d;
      timer_count_q  <= timer_count_d;
      timer_reload_q <= timer_reload_d;
      short_mode_q   <= short_mode_d;
      fixed_volume_q <= fixed_volume_d;
      loop_flag_q    <= loop_flag_d;
      env_on_q       <= env_on_d;
      restart_q      <= restart_d;
      env_divider_q  <= env_divider_d;
      env_level_q    <= env_level_d;
      len_count_q    <= len_count_d;
      chan_enabled_q <= chan_enabled_d;
    end
  end

  // Output register and skid register valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_xfer) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_xfer) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_xfer) begin
        out_q <= skid_q;
      end
    end else if (in_xfer) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};

  // The skid entry is only ever filled behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output register is empty");

  // A transfer taken while the receiver stalls lands in the skid register.
  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && out_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("result lost while the receiver stalled");

  // The shift register never falls into the all-zero lock-up state.
  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0)
    else $error("noise shift register reached zero");

  // Disabling the channel clears the length count.
  a_disable_clears_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (op == OP_ENABLE) && (s_axis_tdata == 8'd0))
      |=> (len_count_q == 8'd0) && !chan_enabled_q)
    else $error("enable write of zero left the length count set");

endmodule

// ===== test/noise_channel_checker.sv =====
`timescale 1ns / 100ps

// Watches both streams of the noise channel, predicts the result of every
// input transfer and compares each output transfer against the oldest
// prediction still waiting.
module noise_channel_checker
  import ncle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,       // [7:0] data
  input  logic [2:0]  s_tuser_i,       // [2:0] op
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,       // [0] noise_bit, [4:1] envelope_level,
                                       // [8:5] volume, [16:9] length_count,
                                       // [17] channel_on, [23:18] zero
  output int          error_count_o,
  output int          pending_o
);

  // Timer periods and length counts indexed by the register writes.
  localparam logic [TimerWidth-1:0] TimerPeriods [0:15] = '{
    12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160,
    12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034, 12'd4068
  };
  localparam logic [7:0] LengthCounts [0:31] = '{
    8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
    8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  typedef struct packed {
    logic [LfsrWidth-1:0]  lfsr;
    logic [TimerWidth-1:0] timer_count;
    logic [TimerWidth-1:0] timer_reload;
    logic                  short_mode;
    logic [3:0]            fixed_volume;
    logic                  loop_flag;
    logic                  env_on;
    logic                  length_on;
    logic                  restart_pending;
    logic [3:0]            env_divider;
    logic [3:0]            env_level;
    logic [7:0]            len_count;
    logic                  chan_enabled;
  } channel_state_t;

  channel_state_t channel;
  channel_state_t channel_next;
  ncle_result_t   expected_results [$];
  ncle_result_t   wanted;
  ncle_result_t   seen;
  int             errors;

  // Applies one item to the channel state and gives the result it reports.
  function automatic ncle_result_t channel_response(input channel_state_t cur,
                                                    input logic [2:0] op,
                                                    input logic [7:0] data,
                                                    output channel_state_t nxt);
    ncle_result_t res;
    logic         feedback;
    nxt = cur;
    case (op)
      OP_CONTROL: begin
        nxt.fixed_volume    = data[3:0];
        nxt.env_on          = ~data[4];
        nxt.loop_flag       = data[5];
        nxt.length_on       = ~data[5];
        nxt.restart_pending = 1'b1;
      end
      OP_PERIOD: begin
        nxt.timer_reload = TimerPeriods[data[3:0]];
        nxt.short_mode   = data[7];
      end
      OP_LENGTH: begin
        nxt.len_count       = LengthCounts[data[7:3]];
        nxt.restart_pending = 1'b1;
      end
      OP_ENABLE: begin
        nxt.chan_enabled = (data != 8'd0);
        if (data == 8'd0) begin
          nxt.len_count = 8'd0;
        end
      end
      OP_TIMER: begin
        // The register shifts only when the divider has run down to zero.
        if (cur.timer_count == '0) begin
          feedback = cur.lfsr[0] ^ (cur.short_mode ? cur.lfsr[TapShort] : cur.lfsr[TapLong]);
          nxt.timer_count = cur.timer_reload;
          nxt.lfsr        = {feedback, cur.lfsr[LfsrWidth-1:1]};
        end else begin
          nxt.timer_count = cur.timer_count - 1'b1;
        end
      end
      OP_ENVELOPE: begin
        if (cur.restart_pending) begin
          nxt.env_level       = EnvTop;
          nxt.env_divider     = cur.fixed_volume;
          nxt.restart_pending = 1'b0;
        end else if (cur.env_divider != 4'd0) begin
          nxt.env_divider = cur.env_divider - 1'b1;
        end else begin
          if (cur.env_level != 4'd0) begin
            nxt.env_level = cur.env_level - 1'b1;
          end else if (cur.loop_flag) begin
            nxt.env_level = EnvTop;
          end
          nxt.env_divider = cur.fixed_volume;
        end
      end
      default: begin
        // Spare codes leave the state alone but still report a result.
      end
    endcase
    res.noise_bit      = nxt.lfsr[0];
    res.envelope_level = nxt.env_level;
    res.volume         = nxt.env_on ? nxt.env_level : nxt.fixed_volume;
    res.length_count   = nxt.len_count;
    res.channel_on     = nxt.chan_enabled;
    return res;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Results are taken off before new predictions go on, since a result can
  // never belong to an item accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel      = '0;
      channel.lfsr = 15'd1;
      expected_results.delete();
      errors = 0;
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no expectation waiting: tdata %h", m_tdata_i);
          errors++;
        end else begin
          wanted = expected_results.pop_front();
          seen   = m_tdata_i[17:0];
          compare_field("noise_bit", wanted.noise_bit, seen.noise_bit);
          compare_field("envelope_level", wanted.envelope_level, seen.envelope_level);
          compare_field("volume", wanted.volume, seen.volume);
          compare_field("length_count", wanted.length_count, seen.length_count);
          compare_field("channel_on", wanted.channel_on, seen.channel_on);
          compare_field("padding", 0, m_tdata_i[23:18]);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_results.push_back(channel_response(channel, s_tuser_i, s_tdata_i,
                                                    channel_next));
        channel = channel_next;
      end
      error_count_o <= errors;
      pending_o     <= expected_results.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

// Drives register writes and ticks into the noise channel, stalls the result
// stream at random and gives the verdict from the checker's error count.
module testbench;
  import ncle_pkg::*;

  // Codes the channel does not use; they must leave its state alone.
  localparam logic [2:0] OpSpareLow  = 3'd6;
  localparam logic [2:0] OpSpareHigh = 3'd7;

  localparam int unsigned RandomItems = 1250;
  localparam int unsigned StallLimit  = 1000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] data
  logic [2:0]  s_axis_tuser  = 3'd0;   // [2:0] op
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [23:0] m_axis_tdata;           // [0] noise_bit, [4:1] envelope_level,
                                       // [8:5] volume, [16:9] length_count,
                                       // [17] channel_on, [23:18] zero

  int          failures;
  int          outstanding;
  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;
  logic        steady_phase = 1'b0;

  always #6 clk_i = ~clk_i;

  noise_channel_lfsr_envelope_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  noise_channel_checker scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .error_count_o (failures),
    .pending_o     (outstanding)
  );

  // Mostly short idle gaps, now and then a long one.
  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_phase || roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Offers one item and returns at the edge where its transfer happens.
  task automatic send_item(input logic [2:0] op, input logic [7:0] data);
    int unsigned gap;
    gap = gap_length();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Result side: random stalls between bursts of readiness.
  initial begin
    int unsigned hold;
    forever begin
      hold = gap_length();
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Watchdog on cycles without any transfer on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [7:0]  data;
    int unsigned burst;
    int unsigned roll;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: ticks straight after reset, extreme writes, spare codes
    // and a length load while the channel is disabled.
    send_item(OP_TIMER, 8'h00);
    send_item(OP_TIMER, 8'hFF);
    send_item(OP_ENVELOPE, 8'h00);
    send_item(OP_CONTROL, 8'h00);
    send_item(OP_ENVELOPE, 8'hFF);
    send_item(OP_ENVELOPE, 8'h00);
    send_item(OP_CONTROL, 8'hFF);
    send_item(OP_CONTROL, 8'h1F);
    send_item(OP_CONTROL, 8'h20);
    send_item(OP_PERIOD, 8'h00);
    send_item(OP_PERIOD, 8'h8F);
    send_item(OP_PERIOD, 8'h80);
    send_item(OP_TIMER, 8'h00);
    send_item(OP_TIMER, 8'h00);
    send_item(OP_TIMER, 8'hFF);
    send_item(OP_LENGTH, 8'h00);
    send_item(OP_LENGTH, 8'hFF);
    send_item(OP_LENGTH, 8'h08);
    send_item(OP_ENABLE, 8'h00);
    send_item(OP_ENABLE, 8'h80);
    send_item(OP_ENABLE, 8'h01);
    send_item(OP_LENGTH, 8'hF8);
    send_item(OpSpareLow, 8'hFF);
    send_item(OpSpareHigh, 8'h00);
    send_item(OP_ENVELOPE, 8'h00);

    // Random part: register set-up followed by a burst of ticks, with a few
    // stray writes and spare codes mixed in.
    items_sent = 0;
    while (items_sent < RandomItems) begin
      steady_phase <= ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 8) begin
        data = 8'($urandom);
        if ($urandom_range(0, 3) != 0) data[3:0] = 4'($urandom_range(0, 2));
        send_item(OP_CONTROL, data);
      end
      if ($urandom_range(0, 9) < 7) begin
        data = 8'($urandom);
        if ($urandom_range(0, 3) != 0) data[3:0] = 4'($urandom_range(0, 2));
        send_item(OP_PERIOD, data);
      end
      if ($urandom_range(0, 9) < 6) begin
        send_item(OP_LENGTH, 8'($urandom));
      end
      if ($urandom_range(0, 9) < 4) begin
        data = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        send_item(OP_ENABLE, data);
      end
      burst = $urandom_range(10, 60);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          send_item(OP_TIMER, 8'($urandom));
        end else if (roll < 90) begin
          send_item(OP_ENVELOPE, 8'($urandom));
        end else if (roll < 94) begin
          send_item(3'($urandom_range(0, 3)), 8'($urandom));
        end else if (roll < 97) begin
          send_item(($urandom_range(0, 1) == 0) ? OpSpareLow : OpSpareHigh, 8'($urandom));
        end else begin
          send_item(3'($urandom_range(0, 7)), 8'($urandom));
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    steady_phase  <= 1'b0;

    // Drain the remaining results, then wait a little longer for strays.
    do @(posedge clk_i); while (outstanding != 0);
    repeat (10) @(posedge clk_i);

    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
